/* rtl/dda_line_rasterizer_assert.svh */
// Assertion macros for the DDA line rasteriser.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define DDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dda assertion failed");
`define DDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dda assertion failed");
`else
`define DDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/dda_pkg.sv */
// Shared types, constants and helpers for the DDA line rasteriser.
`timescale 1ns / 1ps
package dda_pkg;

  localparam int CoordW          = 6;
  localparam int CoordRange      = 64;
  localparam int CfgW            = 7;
  localparam int AddrW           = 12;
  localparam int CountW          = 7;
  localparam int RegIdxW         = 4;
  localparam int FracBitsDefault = 16;

  localparam logic [RegIdxW-1:0] RegScreenWidth  = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegScreenHeight = RegIdxW'(1);

  localparam logic [CfgW-1:0] ScreenWidthReset  = CfgW'(60);
  localparam logic [CfgW-1:0] ScreenHeightReset = CfgW'(30);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DRAW
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [AddrW-1:0]  pixel_address;
    logic              inside_res;
    logic              last;
  } pix_t;

  typedef struct packed {
    logic [RegIdxW-1:0] reg_index;
    logic [CfgW-1:0]    wdata;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dividend;
    logic [CoordW-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic              load;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] steps;
  } stp_ctrl_t;

  typedef struct packed {
    logic active;
    logic done;
  } stp_status_t;

  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] lim;
    lim = CoordW'(CoordRange - 1);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/dda_stream_if.sv */
// Valid/ready channel carrying one request of a given payload type.
`timescale 1ns / 1ps
interface dda_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dda_div.sv */
// Shared serial divider: (dividend << FRAC_BITS) / divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
module dda_div
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctrl_t            ctrl_i,
  output div_status_t          status_o,
  output logic [FRAC_BITS:0]   quot_o
);

  localparam int QuotW = FRAC_BITS + 1;
  localparam int CntW  = $clog2(FRAC_BITS + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [CoordW-1:0] dvs_q, dvs_d;
  logic [QuotW-1:0]  quot_q, quot_d;

  logic [CoordW:0]   trial;
  logic [CoordW:0]   diff;
  logic              ge;

  always_comb begin
    // first cycle compares the plain remainder: integer bit of the quotient
    trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = ctrl_i.dividend;
      dvs_d  = ctrl_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[CoordW-1:0] : trial[CoordW-1:0];
      quot_d = {quot_q[QuotW-2:0], ge};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(FRAC_BITS)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

/* rtl/dda_stepper.sv */
// Accumulator stepper and pixel output register.
`timescale 1ns / 1ps
module dda_stepper
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CfgW-1:0]      width_i,
  input  logic [CfgW-1:0]      height_i,
  input  stp_ctrl_t            ctrl_i,
  input  logic [FRAC_BITS+1:0] x_inc_i,
  input  logic [FRAC_BITS+1:0] y_inc_i,
  output stp_status_t          status_o,
  dda_stream_if.source         pix_o
);

  localparam int AccW = CoordW + FRAC_BITS;
  localparam int IncW = FRAC_BITS + 2;
  localparam int ProdW = CoordW + CfgW;

  logic              active_q, active_d;
  logic [CountW-1:0] left_q, left_d;
  logic [AccW-1:0]   acc_x_q, acc_x_d;
  logic [AccW-1:0]   acc_y_q, acc_y_d;
  logic [IncW-1:0]   inc_x_q, inc_x_d;
  logic [IncW-1:0]   inc_y_q, inc_y_d;
  logic              out_valid_q, out_valid_d;
  pix_t              out_q, out_d;

  logic              adv;
  logic [CoordW-1:0] px, py;
  logic [ProdW-1:0]  addr_sum;

  assign adv = active_q && (!out_valid_q || pix_o.ready);
  assign px  = acc_x_q[AccW-1 -: CoordW];
  assign py  = acc_y_q[AccW-1 -: CoordW];

  always_comb begin
    addr_sum = ({{CfgW{1'b0}}, py} * {{CoordW{1'b0}}, width_i}) + {{CfgW{1'b0}}, px};
  end

  always_comb begin
    active_d    = active_q;
    left_d      = left_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    inc_x_d     = inc_x_q;
    inc_y_d     = inc_y_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pix_o.ready;
    if (ctrl_i.load) begin
      active_d = 1'b1;
      left_d   = {1'b0, ctrl_i.steps} + CountW'(1);
      acc_x_d  = {ctrl_i.x1, {FRAC_BITS{1'b0}}};
      acc_y_d  = {ctrl_i.y1, {FRAC_BITS{1'b0}}};
      inc_x_d  = x_inc_i;
      inc_y_d  = y_inc_i;
    end else if (adv) begin
      out_valid_d         = 1'b1;
      out_d.pixel_x       = px;
      out_d.pixel_y       = py;
      out_d.pixel_address = addr_sum[AddrW-1:0];
      out_d.inside_res    = ({1'b0, px} < width_i) && ({1'b0, py} < height_i);
      out_d.last          = (left_q == CountW'(1));
      acc_x_d = acc_x_q + {{(AccW-IncW){inc_x_q[IncW-1]}}, inc_x_q};
      acc_y_d = acc_y_q + {{(AccW-IncW){inc_y_q[IncW-1]}}, inc_y_q};
      left_d  = left_q - CountW'(1);
      if (left_q == CountW'(1)) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_x_q <= acc_x_d;
    acc_y_q <= acc_y_d;
    inc_x_q <= inc_x_d;
    inc_y_q <= inc_y_d;
    out_q   <= out_d;
  end

  assign status_o.active = active_q;
  assign status_o.done   = adv && (left_q == CountW'(1));
  assign pix_o.valid     = out_valid_q;
  assign pix_o.data      = out_q;

endmodule

/* rtl/dda_line_rasterizer.sv */
// Top level of the DDA line rasteriser: sequencer, config registers, divider and stepper.
//
//   channel  dir  payload                                            handshake
//   seg_i    in   start_x, start_y, end_x, end_y                     valid/ready
//   pix_o    out  pixel_x, pixel_y, pixel_address, inside_res, last  valid/ready
//   cfg_i    in   reg_index, wdata                                   valid/ready
//
// Both increments come from the one serial divider, x first and then y, and then the
// stepper gives one pixel per cycle while pix_o does not stall.
// A zero-length segment is accepted and yields nothing.
// seg_i is ready only when the sequencer is idle; cfg_i is always ready.
// A stall on pix_o holds the stepper; the registered pixel stays until taken.
// Reset returns the sequencer to idle and the screen size to 60 by 30.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_assert.svh"
module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dda_stream_if.sink   seg_i,
  dda_stream_if.source pix_o,
  dda_stream_if.sink   cfg_i
);

  localparam int QuotW = FRAC_BITS + 1;
  localparam int IncW  = FRAC_BITS + 2;

  state_e            state_q, state_d;
  logic [CfgW-1:0]   width_q, height_q;
  logic [CoordW-1:0] x1_q, y1_q, steps_q, mag_y_q;
  logic              neg_x_q, neg_y_q;
  logic [IncW-1:0]   x_inc_q;

  logic [CoordW-1:0] x1_c, y1_c, x2_c, y2_c, sx_c, sy_c, steps_c;
  logic              seg_acc;

  div_ctrl_t         div_ctrl;
  div_status_t       div_status;
  logic [QuotW-1:0]  quot;
  logic [IncW-1:0]   y_inc;
  stp_ctrl_t         stp_ctrl;
  stp_status_t       stp_status;

  always_comb begin
    x1_c    = clamp_coord(seg_i.data.start_x);
    y1_c    = clamp_coord(seg_i.data.start_y);
    x2_c    = clamp_coord(seg_i.data.end_x);
    y2_c    = clamp_coord(seg_i.data.end_y);
    sx_c    = abs_diff(x2_c, x1_c);
    sy_c    = abs_diff(y2_c, y1_c);
    steps_c = (sx_c > sy_c) ? sx_c : sy_c;
  end

  assign seg_acc = seg_i.valid && seg_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (seg_acc && steps_c != '0) state_d = ST_DIV_X;
      ST_DIV_X: if (div_status.done) state_d = ST_DIV_Y;
      ST_DIV_Y: if (div_status.done) state_d = ST_DRAW;
      ST_DRAW:  if (stp_status.done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    seg_i.ready       = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = mag_y_q;
    div_ctrl.divisor  = steps_q;
    stp_ctrl.load     = 1'b0;
    stp_ctrl.x1       = x1_q;
    stp_ctrl.y1       = y1_q;
    stp_ctrl.steps    = steps_q;
    unique case (state_q)
      ST_IDLE: begin
        seg_i.ready       = 1'b1;
        div_ctrl.start    = seg_i.valid && (steps_c != '0);
        div_ctrl.dividend = sx_c;
        div_ctrl.divisor  = steps_c;
      end
      ST_DIV_X: div_ctrl.start = div_status.done;
      ST_DIV_Y: stp_ctrl.load  = div_status.done;
      ST_DRAW:  ;
      default:  ;
    endcase
  end

  assign y_inc = neg_y_q ? (IncW'(0) - {1'b0, quot}) : {1'b0, quot};
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= ScreenWidthReset;
      height_q <= ScreenHeightReset;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.data.reg_index)
          RegScreenWidth:  width_q  <= cfg_i.data.wdata;
          RegScreenHeight: height_q <= cfg_i.data.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_acc) begin
      x1_q    <= x1_c;
      y1_q    <= y1_c;
      steps_q <= steps_c;
      mag_y_q <= sy_c;
      neg_x_q <= x2_c < x1_c;
      neg_y_q <= y2_c < y1_c;
    end
    if (state_q == ST_DIV_X && div_status.done) begin
      x_inc_q <= neg_x_q ? (IncW'(0) - {1'b0, quot}) : {1'b0, quot};
    end
  end

  dda_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .status_o (div_status),
    .quot_o   (quot)
  );

  dda_stepper #(
    .FRAC_BITS (FRAC_BITS)
  ) u_stepper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .ctrl_i   (stp_ctrl),
    .x_inc_i  (x_inc_q),
    .y_inc_i  (y_inc),
    .status_o (stp_status),
    .pix_o    (pix_o)
  );

  `DDA_ASSERT_IMP(a_start_idle_div, clk_i, rst_ni, div_ctrl.start, !div_status.busy)
  `DDA_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_status.done, (state_q == ST_DIV_X || state_q == ST_DIV_Y))
  `DDA_ASSERT_IMP(a_held_is_last, clk_i, rst_ni, pix_o.valid && !stp_status.active, pix_o.data.last)
  `DDA_ASSERT_NEXT(a_load_starts, clk_i, rst_ni, stp_ctrl.load, stp_status.active)

endmodule

/* dv/dda_pixel_checker.sv */
`timescale 1ns / 1ps
// Pixel checker: traces each accepted segment and compares the pixel stream against it.
module dda_pixel_checker
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic seg_valid_i,
  input  logic seg_ready_i,
  input  seg_t seg_data_i,
  input  logic pix_valid_i,
  input  logic pix_ready_i,
  input  pix_t pix_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  cfg_t cfg_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [CfgW-1:0] screen_w;
  logic [CfgW-1:0] screen_h;
  pix_t            expected_pixels [$];
  int              fails;

  function automatic logic [31:0] axis_step(input logic [CoordW-1:0] from,
                                            input logic [CoordW-1:0] to,
                                            input logic [CoordW-1:0] steps);
    logic [31:0] span;
    logic [31:0] q;
    span = (to >= from) ? 32'(to - from) : 32'(from - to);
    q = (span << FRAC_BITS) / 32'(steps);
    return (to >= from) ? q : -q;
  endfunction

  // 6-bit endpoints can never lie beyond the raster, so no saturation is needed
  function automatic void trace_line(input seg_t s);
    logic [CoordW-1:0] span_x;
    logic [CoordW-1:0] span_y;
    logic [CoordW-1:0] steps;
    logic [31:0]       acc_x;
    logic [31:0]       acc_y;
    logic [31:0]       inc_x;
    logic [31:0]       inc_y;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    pix_t              p;
    span_x = (s.end_x >= s.start_x) ? s.end_x - s.start_x : s.start_x - s.end_x;
    span_y = (s.end_y >= s.start_y) ? s.end_y - s.start_y : s.start_y - s.end_y;
    steps  = (span_x > span_y) ? span_x : span_y;
    if (steps == 0) return;
    inc_x = axis_step(s.start_x, s.end_x, steps);
    inc_y = axis_step(s.start_y, s.end_y, steps);
    acc_x = 32'(s.start_x) << FRAC_BITS;
    acc_y = 32'(s.start_y) << FRAC_BITS;
    for (int n = 0; n <= int'(steps); n++) begin
      px = acc_x[FRAC_BITS +: CoordW];
      py = acc_y[FRAC_BITS +: CoordW];
      p.pixel_x       = px;
      p.pixel_y       = py;
      p.pixel_address = AddrW'(int'(py) * int'(screen_w) + int'(px));
      p.inside_res    = (px < screen_w) && (py < screen_h);
      p.last          = (n == int'(steps));
      expected_pixels.insert(expected_pixels.size(), p);
      acc_x += inc_x;
      acc_y += inc_y;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pix_t want;
    if (!rst_ni) begin
      screen_w = ScreenWidthReset;
      screen_h = ScreenHeightReset;
      expected_pixels.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pix_valid_i && pix_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d", pix_data_i.pixel_x, pix_data_i.pixel_y);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_data_i.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix_data_i.pixel_x);
            fails++;
          end
          if (pix_data_i.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix_data_i.pixel_y);
            fails++;
          end
          if (pix_data_i.pixel_address !== want.pixel_address) begin
            $error("pixel_address: expected %0d, got %0d",
                   want.pixel_address, pix_data_i.pixel_address);
            fails++;
          end
          if (pix_data_i.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d", want.inside_res, pix_data_i.inside_res);
            fails++;
          end
          if (pix_data_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, pix_data_i.last);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.reg_index)
          RegScreenWidth:  screen_w = cfg_data_i.wdata;
          RegScreenHeight: screen_h = cfg_data_i.wdata;
          default: ;
        endcase
      end
      if (seg_valid_i && seg_ready_i) trace_line(seg_data_i);
      fail_count_o <= fails;
      pending_o <= expected_pixels.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the line rasteriser testbench: clock, reset, segment and register stimulus, verdict.
module tb_top;
  import dda_pkg::*;

  localparam int DrainCycles   = 2 * (FracBitsDefault + 2) + 8;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 5000;
  localparam int PhaseItems    = 42;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_hold = 1'b0;
  int   tx_gap_pct;
  int   rx_stall_pct;
  int   fail_count;
  int   pixels_pending;
  int   quiet_cycles;

  dda_stream_if #(.payload_t(seg_t)) seg_if ();
  dda_stream_if #(.payload_t(pix_t)) pix_if ();
  dda_stream_if #(.payload_t(cfg_t)) cfg_if ();

  dda_line_rasterizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if),
    .pix_o  (pix_if),
    .cfg_i  (cfg_if)
  );

  dda_pixel_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_valid_i  (seg_if.valid),
    .seg_ready_i  (seg_if.ready),
    .seg_data_i   (seg_if.data),
    .pix_valid_i  (pix_if.valid),
    .pix_ready_i  (pix_if.ready),
    .pix_data_i   (pix_if.data),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_data_i   (cfg_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pixels_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      pix_if.ready <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (seg_if.valid && seg_if.ready) || (pix_if.valid && pix_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("dda_line_rasterizer verification failed");
      $finish;
    end
  end

  function automatic seg_t segment_of(input int ax, input int ay, input int bx, input int by);
    return '{start_x: CoordW'(ax), start_y: CoordW'(ay), end_x: CoordW'(bx), end_y: CoordW'(by)};
  endfunction

  function automatic int near(input int v);
    int r;
    r = v + int'($urandom_range(8)) - 4;
    return (r < 0) ? 0 : (r > CoordRange - 1) ? CoordRange - 1 : r;
  endfunction

  function automatic seg_t random_segment();
    int kind;
    int ax;
    int ay;
    int bx;
    int by;
    kind = $urandom_range(99);
    ax = $urandom_range(63);
    ay = $urandom_range(63);
    bx = $urandom_range(63);
    by = $urandom_range(63);
    if (kind < 8) begin
      bx = ax;
      by = ay;
    end else if (kind < 20) begin
      ax = 63 * $urandom_range(1);
      ay = 63 * $urandom_range(1);
      bx = 63 * $urandom_range(1);
      by = 63 * $urandom_range(1);
    end else if (kind < 45) begin
      bx = near(ax);
      by = near(ay);
    end else if (kind < 55) begin
      if ($urandom_range(1)) bx = ax;
      else by = ay;
    end
    return segment_of(ax, ay, bx, by);
  endfunction

  // valid stays high between back-to-back requests
  task automatic send_segment(input seg_t s);
    if ($urandom_range(99) < tx_gap_pct) begin
      seg_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_gap_pct);
    end
    seg_if.valid <= 1'b1;
    seg_if.data <= s;
    do @(posedge clk_i); while (!seg_if.ready);
  endtask

  task automatic configure_screen(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{reg_index: RegScreenWidth, wdata: w};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.data <= '{reg_index: RegScreenHeight, wdata: h};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    seg_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int widths [6];
    int heights [6];
    widths  = '{64, 1, 127, 0, 40, 0};
    heights = '{64, 1, 100, 0, 17, 0};
    rst_ni = 1'b0;
    seg_if.valid <= 1'b0;
    seg_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    tx_gap_pct = 12;
    rx_stall_pct = 60;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset screen size of 60 by 30
    send_segment(segment_of(0, 0, 63, 63));
    send_segment(segment_of(63, 63, 0, 0));
    send_segment(segment_of(0, 63, 63, 0));
    send_segment(segment_of(63, 0, 0, 63));
    send_segment(segment_of(0, 5, 63, 5));
    send_segment(segment_of(63, 5, 0, 5));
    send_segment(segment_of(7, 0, 7, 63));
    send_segment(segment_of(7, 63, 7, 0));
    send_segment(segment_of(10, 10, 10, 10));
    send_segment(segment_of(0, 0, 0, 0));
    send_segment(segment_of(63, 63, 63, 63));
    send_segment(segment_of(0, 0, 63, 1));
    send_segment(segment_of(0, 0, 1, 63));
    send_segment(segment_of(63, 63, 62, 0));
    send_segment(segment_of(3, 4, 4, 4));
    send_segment(segment_of(3, 4, 3, 3));
    send_segment(segment_of(50, 20, 63, 40));
    send_segment(segment_of(40, 10, 3, 50));
    send_segment(segment_of(59, 29, 60, 30));
    send_segment(segment_of(21, 42, 42, 21));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      tx_gap_pct   = (ph < 2) ? 12 : (ph < 4) ? 60 : 0;
      rx_stall_pct = (ph < 2) ? 60 : (ph < 4) ? 12 : 0;
      if (ph == 5) begin
        widths[5]  = $urandom_range(127);
        heights[5] = $urandom_range(127);
      end
      configure_screen(CfgW'(widths[ph]), CfgW'(heights[ph]));
      if (ph == 4) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
        send_segment(segment_of(0, 0, 63, 40));
        send_segment(segment_of(63, 10, 0, 50));
      end
      repeat (PhaseItems) send_segment(random_segment());
      settle();
    end

    if (fail_count == 0 && pixels_pending == 0) begin
      $display("dda_line_rasterizer verification clean");
    end else begin
      $display("dda_line_rasterizer verification failed");
    end
    $finish;
  end

endmodule
